// ===== src/mise_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mise_pkg
// Shared types, instruction classes and constants of the integer executor.
// ----------------------------------------------------------------------------
package mise_pkg;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] SP_RESET   = 32'h0100_0000;
  localparam logic [31:0] JUMP_MASK  = 32'hF000_0000;
  localparam logic [4:0]  REG_SP     = 5'd29;
  localparam logic [4:0]  REG_RA     = 5'd31;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Major opcodes.
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // Function codes of the register format.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // Execution classes.
  localparam logic [4:0] C_ILL   = 5'd0;
  localparam logic [4:0] C_ADD   = 5'd1;
  localparam logic [4:0] C_SUB   = 5'd2;
  localparam logic [4:0] C_AND   = 5'd3;
  localparam logic [4:0] C_OR    = 5'd4;
  localparam logic [4:0] C_NOR   = 5'd5;
  localparam logic [4:0] C_SLT   = 5'd6;
  localparam logic [4:0] C_SLTU  = 5'd7;
  localparam logic [4:0] C_SLL   = 5'd8;
  localparam logic [4:0] C_SRL   = 5'd9;
  localparam logic [4:0] C_JR    = 5'd10;
  localparam logic [4:0] C_ADDI  = 5'd11;
  localparam logic [4:0] C_ANDI  = 5'd12;
  localparam logic [4:0] C_ORI   = 5'd13;
  localparam logic [4:0] C_SLTI  = 5'd14;
  localparam logic [4:0] C_SLTIU = 5'd15;
  localparam logic [4:0] C_LUI   = 5'd16;
  localparam logic [4:0] C_LW    = 5'd17;
  localparam logic [4:0] C_SW    = 5'd18;
  localparam logic [4:0] C_BEQ   = 5'd19;
  localparam logic [4:0] C_BNE   = 5'd20;
  localparam logic [4:0] C_J     = 5'd21;
  localparam logic [4:0] C_JAL   = 5'd22;

  typedef struct packed {
    logic [4:0]  cls;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [25:0] tgt;
    logic        wr;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        store_done;
    logic        halted;
    logic        illegal;
  } res_t;

  function automatic logic [31:0] gpr_reset(input logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx == REG_SP) v = SP_RESET;
    if (idx == REG_RA) v = ALL_ONES;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/mise_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mise_front
// Accepts instruction beats and classifies them into decoded queue entries.
// ----------------------------------------------------------------------------
module mise_front import mise_pkg::*; (
  input  wire logic        in_valid,
  input  wire logic [31:0] in_instr_word,
  input  wire logic        busy,
  input  wire logic        q_full,
  output logic             in_stall,
  output logic             push,
  output dec_t             push_dec
);

  logic [5:0] op;
  logic [5:0] fn;

  assign op       = in_instr_word[31:26];
  assign fn       = in_instr_word[5:0];
  assign in_stall = busy || q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    logic [4:0] cls;
    logic       wr;
    logic [4:0] dst;
    cls = C_ILL;
    wr  = 1'b0;
    dst = in_instr_word[20:16];
    if (op == OP_RTYPE) begin
      dst = in_instr_word[15:11];
      wr  = 1'b1;
      case (fn)
        FN_ADD, FN_ADDU: cls = C_ADD;
        FN_SUB, FN_SUBU: cls = C_SUB;
        FN_AND:          cls = C_AND;
        FN_OR:           cls = C_OR;
        FN_NOR:          cls = C_NOR;
        FN_SLT:          cls = C_SLT;
        FN_SLTU:         cls = C_SLTU;
        FN_SLL:          cls = C_SLL;
        FN_SRL:          cls = C_SRL;
        FN_JR: begin
          cls = C_JR;
          wr  = 1'b0;
        end
        default: begin
          cls = C_ILL;
          wr  = 1'b0;
        end
      endcase
    end else begin
      wr = 1'b1;
      case (op)
        OP_ADDI, OP_ADDIU: cls = C_ADDI;
        OP_ANDI:           cls = C_ANDI;
        OP_ORI:            cls = C_ORI;
        OP_SLTI:           cls = C_SLTI;
        OP_SLTIU:          cls = C_SLTIU;
        OP_LUI:            cls = C_LUI;
        OP_LW:             cls = C_LW;
        OP_SW: begin
          cls = C_SW;
          wr  = 1'b0;
        end
        OP_BEQ: begin
          cls = C_BEQ;
          wr  = 1'b0;
        end
        OP_BNE: begin
          cls = C_BNE;
          wr  = 1'b0;
        end
        OP_J: begin
          cls = C_J;
          wr  = 1'b0;
        end
        OP_JAL: begin
          cls = C_JAL;
          dst = REG_RA;
        end
        default: begin
          cls = C_ILL;
          wr  = 1'b0;
        end
      endcase
    end
    push_dec.cls = cls;
    push_dec.rs  = in_instr_word[25:21];
    push_dec.rt  = in_instr_word[20:16];
    push_dec.dst = dst;
    push_dec.sh  = in_instr_word[10:6];
    push_dec.imm = in_instr_word[15:0];
    push_dec.tgt = in_instr_word[25:0];
    push_dec.wr  = wr && (dst != 5'd0);
  end

endmodule
`default_nettype wire

// ===== src/mise_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mise_queue
// Short queue of decoded instructions between the front and the back.
// ----------------------------------------------------------------------------
module mise_queue import mise_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  dec_t      push_dec,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output dec_t      head
);

  dec_t           slot_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_dec;
  end

endmodule
`default_nettype wire

// ===== src/mise_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mise_back
// Executes decoded instructions against the registers, PC and data memory.
// ----------------------------------------------------------------------------
module mise_back import mise_pkg::*; #(
  parameter int DATA_WORDS = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  dec_t      q_head,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_res
);

  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] dmem [DATA_WORDS];

  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;

  logic        adv;
  logic        e2_vld_r;
  dec_t        e2_dec_r;
  logic [31:0] a_raw_r, b_raw_r;
  logic        a_ok_r, b_ok_r;
  logic [31:0] pc_r;

  logic        e3_vld_r;
  logic        e3_lw_r;
  res_t        e3_res_r;
  logic [31:0] mem_rd_r;
  logic [31:0] e3_val;
  res_t        e3_out;

  logic        w_vld_r;
  logic [4:0]  w_idx_r;
  logic [31:0] w_val_r;

  logic        out_vld_r;
  res_t        out_res_r;

  logic [31:0] a, b;
  res_t        x_res;
  logic        x_lw;
  logic        x_sw;
  logic        x_upd;
  logic [31:0] x_ea;
  logic [AW-1:0] x_widx;

  assign busy      = clr_busy_r;
  assign adv       = !out_vld_r || !out_stall;
  assign pop       = adv && !q_empty;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;
  assign e3_val    = (e3_lw_r && e3_res_r.reg_write) ? mem_rd_r : e3_res_r.write_value;

  always_comb begin
    e3_out             = e3_res_r;
    e3_out.write_value = e3_val;
  end

  function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] raw,
                                      input logic ok, input logic e3v, input res_t e3r,
                                      input logic [31:0] e3x, input logic wv,
                                      input logic [4:0] wi, input logic [31:0] wx);
    logic [31:0] v;
    v = ok ? raw : gpr_reset(idx);
    if (wv && wi == idx) v = wx;
    if (e3v && e3r.reg_write && e3r.write_index == idx) v = e3x;
    return v;
  endfunction

  always_comb begin
    a = fwd(e2_dec_r.rs, a_raw_r, a_ok_r, e3_vld_r, e3_res_r, e3_val,
            w_vld_r, w_idx_r, w_val_r);
    b = fwd(e2_dec_r.rt, b_raw_r, b_ok_r, e3_vld_r, e3_res_r, e3_val,
            w_vld_r, w_idx_r, w_val_r);
  end

  always_comb begin
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] jmp;
    logic [31:0] nxt;
    logic [31:0] val;
    logic        ill;
    simm = {{16{e2_dec_r.imm[15]}}, e2_dec_r.imm};
    pc4  = pc_r + 32'd4;
    jmp  = (pc4 & JUMP_MASK) | {4'd0, e2_dec_r.tgt, 2'b00};
    nxt  = pc4;
    val  = '0;
    ill  = 1'b0;
    x_ea = a + simm;
    x_widx = x_ea[AW+1:2];
    case (e2_dec_r.cls)
      C_ADD:   val = a + b;
      C_SUB:   val = a - b;
      C_AND:   val = a & b;
      C_OR:    val = a | b;
      C_NOR:   val = ~(a | b);
      C_SLT:   val = {31'd0, $signed(a) < $signed(b)};
      C_SLTU:  val = {31'd0, a < b};
      C_SLL:   val = b << e2_dec_r.sh;
      C_SRL:   val = b >> e2_dec_r.sh;
      C_JR:    nxt = a;
      C_ADDI:  val = x_ea;
      C_ANDI:  val = a & {16'd0, e2_dec_r.imm};
      C_ORI:   val = a | {16'd0, e2_dec_r.imm};
      C_SLTI:  val = {31'd0, $signed(a) < $signed(simm)};
      C_SLTIU: val = {31'd0, a < simm};
      C_LUI:   val = {e2_dec_r.imm, 16'd0};
      C_LW:    val = '0;
      C_SW:    val = '0;
      C_BEQ:   if (a == b) nxt = pc4 + {simm[29:0], 2'b00};
      C_BNE:   if (a != b) nxt = pc4 + {simm[29:0], 2'b00};
      C_J:     nxt = jmp;
      C_JAL: begin
        val = pc_r + 32'd8;
        nxt = jmp;
      end
      default: ill = 1'b1;
    endcase
    x_res = '0;
    x_lw  = 1'b0;
    x_sw  = 1'b0;
    x_upd = 1'b0;
    if (pc_r == ALL_ONES) begin
      x_res.next_pc = ALL_ONES;
      x_res.halted  = 1'b1;
    end else if (ill) begin
      x_res.next_pc = pc_r;
      x_res.illegal = 1'b1;
    end else begin
      x_upd               = 1'b1;
      x_lw                = (e2_dec_r.cls == C_LW);
      x_sw                = (e2_dec_r.cls == C_SW);
      x_res.next_pc       = nxt;
      x_res.reg_write     = e2_dec_r.wr;
      x_res.write_index   = e2_dec_r.wr ? e2_dec_r.dst : 5'd0;
      x_res.write_value   = e2_dec_r.wr ? val : 32'd0;
      x_res.store_done    = x_sw;
      x_res.halted        = (nxt == ALL_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      e2_vld_r   <= 1'b0;
      e3_vld_r   <= 1'b0;
      w_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      pc_r       <= '0;
      rf_vld_r   <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DATA_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        e2_vld_r  <= !q_empty;
        e3_vld_r  <= e2_vld_r;
        w_vld_r   <= e3_vld_r && e3_res_r.reg_write;
        out_vld_r <= e3_vld_r;
        if (e2_vld_r && x_upd) pc_r <= x_res.next_pc;
        if (e3_vld_r && e3_res_r.reg_write) rf_vld_r[e3_res_r.write_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_dec_r <= q_head;
      a_raw_r  <= rf_mem[q_head.rs];
      b_raw_r  <= rf_mem[q_head.rt];
      a_ok_r   <= rf_vld_r[q_head.rs];
      b_ok_r   <= rf_vld_r[q_head.rt];
      e3_res_r <= x_res;
      e3_lw_r  <= x_lw;
      w_idx_r  <= e3_res_r.write_index;
      w_val_r  <= e3_val;
      out_res_r <= e3_out;
      if (e3_vld_r && e3_res_r.reg_write) rf_mem[e3_res_r.write_index] <= e3_val;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_cnt_r] <= '0;
    end else if (adv && e2_vld_r && x_sw) begin
      dmem[x_widx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e2_vld_r && x_lw) mem_rd_r <= dmem[x_widx];
  end

  a_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.reg_write |-> out_res_r.write_index != 5'd0)
    else $error("register write reported for index zero");

  a_ill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.illegal |->
      !out_res_r.reg_write && !out_res_r.store_done && !out_res_r.halted)
    else $error("illegal instruction with side effects");

  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !e2_vld_r && !e3_vld_r)
    else $error("instruction in flight during memory clear");

  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(pc_r) == ALL_ONES |-> pc_r == ALL_ONES)
    else $error("program counter left the halted value");

endmodule
`default_nettype wire

// ===== src/mips_integer_subset_executor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_integer_subset_executor
// Executes one MIPS integer instruction per beat and reports its effects.
//
// The driver sends one instruction word per input beat, fetched at the PC
// that the previous result reported (zero after reset). Each input beat
// yields exactly one result beat with the next PC, the register write-back,
// the store flag, halt and illegal. Input and result channels use valid and
// stall; an item moves when valid is high and stall is low.
// A new instruction can be taken every cycle while in_stall is low. Once
// accepted, an instruction is written into a four-entry queue and then
// passes, one registered step each, through register read, execute with
// data memory access, and memory read data with write-back to the result.
// When the result receiver stalls, the back end holds, the queue fills and
// in_stall then rises. After reset the data memory is cleared one word per
// cycle across all DATA_WORDS words, while in_stall stays high. DATA_WORDS
// must be a power of two; word addresses wrap within it.
// ----------------------------------------------------------------------------
module mips_integer_subset_executor import mise_pkg::*; #(
  parameter int DATA_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instr_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_next_pc,
  output logic             out_reg_write,
  output logic [4:0]       out_write_index,
  output logic [31:0]      out_write_value,
  output logic             out_store_done,
  output logic             out_halted,
  output logic             out_illegal
);

  logic busy;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  dec_t push_dec;
  dec_t q_head;
  res_t res;

  mise_front u_front (
    .in_valid      (in_valid),
    .in_instr_word (in_instr_word),
    .busy          (busy),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .push_dec      (push_dec)
  );

  mise_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_dec (push_dec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  mise_back #(
    .DATA_WORDS (DATA_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_next_pc     = res.next_pc;
  assign out_reg_write   = res.reg_write;
  assign out_write_index = res.write_index;
  assign out_write_value = res.write_value;
  assign out_store_done  = res.store_done;
  assign out_halted      = res.halted;
  assign out_illegal     = res.illegal;

endmodule
`default_nettype wire

// ===== tb/mips_integer_subset_executor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_subset_executor_test
// Self-checking testbench for the MIPS integer subset executor.
//
// An instruction stream goes in: a short directed program that touches every
// execution class and several corner cases, then random programs built mostly
// from legal instructions over a few busy registers. A scoreboard keeps its
// own register file, PC and data memory, predicts each result beat when its
// instruction beat is accepted and compares every result field. Random
// streams never reach the halt PC; the run ends by halting the core on
// purpose and sending a few words that must be ignored.
// ----------------------------------------------------------------------------
module mips_integer_subset_executor_test;
  import mise_pkg::*;

  localparam int MEM_WORDS = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1900;

  class exec_scoreboard;
    logic [31:0] gpr [32];
    logic [31:0] pc;
    logic [31:0] mem [MEM_WORDS];
    res_t pending_results [$];
    int errors;
    int accepted;
    int checked;
    int n_illegal;
    int n_store;
    int n_write;

    function new();
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
      gpr[REG_SP] = SP_RESET;
      gpr[REG_RA] = ALL_ONES;
      pc = '0;
      errors = 0;
      accepted = 0;
      checked = 0;
      n_illegal = 0;
      n_store = 0;
      n_write = 0;
    endfunction

    function automatic res_t execute(input logic [31:0] w, input bit commit);
      res_t r;
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sh, dst;
      logic [31:0] imm, simm, a, b, nxt, val, jmp, addr;
      bit wr, st, bad;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sh = w[10:6];
      fn = w[5:0];
      imm = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a = gpr[rs];
      b = gpr[rt];
      nxt = pc + 32'd4;
      jmp = (nxt & JUMP_MASK) | {4'h0, w[25:0], 2'b00};
      addr = a + simm;
      wr = 0;
      st = 0;
      bad = 0;
      dst = rt;
      val = '0;
      r = '0;
      if (pc == ALL_ONES) begin
        r.next_pc = ALL_ONES;
        r.halted = 1'b1;
        return r;
      end
      if (op == OP_RTYPE) begin
        wr = 1;
        dst = rd;
        case (fn)
          FN_ADD, FN_ADDU: val = a + b;
          FN_SUB, FN_SUBU: val = a - b;
          FN_AND: val = a & b;
          FN_OR: val = a | b;
          FN_NOR: val = ~(a | b);
          FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
          FN_SLL: val = b << sh;
          FN_SRL: val = b >> sh;
          FN_JR: begin
            wr = 0;
            nxt = a;
          end
          default: begin
            wr = 0;
            bad = 1;
          end
        endcase
      end else begin
        case (op)
          OP_ADDI, OP_ADDIU: begin wr = 1; val = a + simm; end
          OP_ANDI: begin wr = 1; val = a & imm; end
          OP_ORI: begin wr = 1; val = a | imm; end
          OP_SLTI: begin wr = 1; val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0; end
          OP_SLTIU: begin wr = 1; val = (a < simm) ? 32'd1 : 32'd0; end
          OP_LUI: begin wr = 1; val = imm << 16; end
          OP_LW: begin wr = 1; val = mem[(addr >> 2) % MEM_WORDS]; end
          OP_SW: st = 1;
          OP_BEQ: if (a == b) nxt = pc + 32'd4 + (simm << 2);
          OP_BNE: if (a != b) nxt = pc + 32'd4 + (simm << 2);
          OP_J: nxt = jmp;
          OP_JAL: begin
            wr = 1;
            dst = REG_RA;
            val = pc + 32'd8;
            nxt = jmp;
          end
          default: bad = 1;
        endcase
      end
      if (bad) begin
        r.next_pc = pc;
        r.illegal = 1'b1;
        return r;
      end
      if (wr && dst != 5'd0) begin
        r.reg_write = 1'b1;
        r.write_index = dst;
        r.write_value = val;
        if (commit) gpr[dst] = val;
      end
      if (commit) begin
        if (st) mem[(addr >> 2) % MEM_WORDS] = b;
        pc = nxt;
      end
      r.next_pc = nxt;
      r.store_done = st;
      r.halted = (nxt == ALL_ONES);
      return r;
    endfunction

    function automatic bit would_halt(input logic [31:0] w);
      res_t r;
      r = execute(w, 0);
      return r.halted;
    endfunction

    function automatic void note_instr(input logic [31:0] w);
      res_t r;
      r = execute(w, 1);
      pending_results.push_back(r);
      accepted++;
      n_illegal += r.illegal;
      n_store += r.store_done;
      n_write += r.reg_write;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result beat, next_pc", got.next_pc, '0);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
      if (got.reg_write !== want.reg_write)
        report("reg_write", got.reg_write, want.reg_write);
      if (got.write_index !== want.write_index)
        report("write_index", got.write_index, want.write_index);
      if (got.write_value !== want.write_value)
        report("write_value", got.write_value, want.write_value);
      if (got.store_done !== want.store_done)
        report("store_done", got.store_done, want.store_done);
      if (got.halted !== want.halted) report("halted", got.halted, want.halted);
      if (got.illegal !== want.illegal) report("illegal", got.illegal, want.illegal);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_instr_word;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_next_pc;
  logic out_reg_write;
  logic [4:0] out_write_index;
  logic [31:0] out_write_value;
  logic out_store_done;
  logic out_halted;
  logic out_illegal;

  exec_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  mips_integer_subset_executor #(.DATA_WORDS(MEM_WORDS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_instr_word(in_instr_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_next_pc(out_next_pc),
    .out_reg_write(out_reg_write),
    .out_write_index(out_write_index),
    .out_write_value(out_write_value),
    .out_store_done(out_store_done),
    .out_halted(out_halted),
    .out_illegal(out_illegal)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.next_pc = out_next_pc;
      got.reg_write = out_reg_write;
      got.write_index = out_write_index;
      got.write_value = out_write_value;
      got.store_done = out_store_done;
      got.halted = out_halted;
      got.illegal = out_illegal;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_instr(input logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instr_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_instr(w);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_instr();
    logic [5:0] fns [12];
    logic [5:0] ops [13];
    int k;
    fns = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU,
            FN_SLL, FN_SRL, FN_JR};
    ops = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTI, OP_SLTIU, OP_LUI, OP_LW, OP_SW,
            OP_BEQ, OP_BNE, OP_J, OP_JAL};
    k = $urandom_range(0, 99);
    if (k < 5) return $urandom;
    if (k < 8) return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                            6'($urandom));
    if (k < 50) return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                             fns[$urandom_range(0, 10 + ($urandom_range(0, 3) == 0))]);
    k = $urandom_range(0, 12);
    if (ops[k] == OP_J || ops[k] == OP_JAL) return {ops[k], 26'($urandom)};
    return itype(ops[k], pick_reg(), pick_reg(), pick_imm());
  endfunction

  task send_random(input int count);
    logic [31:0] w;
    int tries;
    for (int i = 0; i < count; i++) begin
      w = random_instr();
      tries = 0;
      while (sb.would_halt(w) && tries < 20) begin
        w = random_instr();
        tries++;
      end
      if (sb.would_halt(w)) w = {6'h3F, 26'($urandom)};
      send_instr(w);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_instr_word = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_instr(32'h0000_0000);
    send_instr(itype(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
    send_instr(itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    send_instr(itype(OP_ADDI, 5'd1, 5'd2, 16'h0001));
    send_instr(rtype(5'd2, 5'd1, 5'd3, 5'd0, FN_SUB));
    send_instr(rtype(5'd1, 5'd2, 5'd4, 5'd0, FN_SLT));
    send_instr(rtype(5'd1, 5'd2, 5'd5, 5'd0, FN_SLTU));
    send_instr(itype(OP_SLTIU, 5'd1, 5'd6, 16'hFFFF));
    send_instr(itype(OP_SLTI, 5'd2, 5'd7, 16'h8000));
    send_instr(itype(OP_ANDI, 5'd31, 5'd8, 16'hFFFF));
    send_instr(rtype(5'd0, 5'd31, 5'd9, 5'd31, FN_SLL));
    send_instr(rtype(5'd0, 5'd31, 5'd10, 5'd31, FN_SRL));
    send_instr(rtype(5'd1, 5'd2, 5'd11, 5'd0, FN_NOR));
    send_instr(rtype(5'd1, 5'd2, 5'd12, 5'd0, FN_AND));
    send_instr(rtype(5'd1, 5'd2, 5'd13, 5'd0, FN_OR));
    send_instr(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_ADDU));
    send_instr(itype(OP_SW, 5'd29, 5'd1, 16'hFFFF));
    send_instr(itype(OP_LW, 5'd29, 5'd14, 16'hFFFC));
    send_instr(itype(OP_BEQ, 5'd1, 5'd14, 16'hFFFE));
    send_instr(itype(OP_BNE, 5'd1, 5'd14, 16'h0003));
    send_instr({OP_JAL, 26'h3FF_FFFF});
    send_instr({OP_J, 26'h000_0010});
    send_instr(rtype(5'd29, 5'd0, 5'd0, 5'd0, FN_JR));
    send_instr(rtype(5'd1, 5'd2, 5'd3, 5'd0, 6'h3F));
    send_instr(32'hFFFF_FFFF);

    wait_drained();
    send_random(RANDOM_ITEMS / 4);
    send_idle_pct = 86;
    send_random(RANDOM_ITEMS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    send_random(RANDOM_ITEMS / 4);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    send_random(RANDOM_ITEMS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    send_instr(itype(OP_LUI, 5'd0, 5'd1, 16'hFFFF));
    send_instr(itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    send_instr(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_JR));
    send_instr(itype(OP_ADDI, 5'd0, 5'd2, 16'h0005));
    send_instr(32'hFFFF_FFFF);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d instructions, checked %0d results, %0d mismatches.",
             sb.accepted, sb.checked, sb.errors);
    $display("Seen: %0d register writes, %0d stores, %0d illegal words, halt at the end.",
             sb.n_write, sb.n_store, sb.n_illegal);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
